>>> rtl/periodic_token_bucket_limiter_defines.svh
// Assertion macros shared by the token bucket limiter RTL.
`ifndef PERIODIC_TOKEN_BUCKET_LIMITER_DEFINES_SVH
`define PERIODIC_TOKEN_BUCKET_LIMITER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define PTBL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define PTBL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/ptbl_pkg.sv
// Package: types and constants of the token bucket limiter.
`default_nettype none

package ptbl_pkg;

   localparam int TOKEN_WIDTH_DEFAULT  = 32;
   localparam int PERIOD_WIDTH_DEFAULT = 24;
   localparam int REFILL_PERIOD_RESET  = 1000;

   localparam int CSR_INDEX_WIDTH = 8;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BUCKET_CAPACITY = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_REFILL_PERIOD   = 8'd1;

   localparam logic FUNC_TICK    = 1'b0;
   localparam logic FUNC_REQUEST = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE    = 3'd0,
      ST_WAITING = 3'd1,
      ST_DONE    = 3'd2,
      ST_BUSY    = 3'd3,
      ST_ZEROCAP = 3'd4
   } status_type;

endpackage

`default_nettype wire

>>> rtl/ptbl_engine.sv
// Bucket state registers and the per-word update logic.
`default_nettype none

`include "periodic_token_bucket_limiter_defines.svh"

module ptbl_engine #(
   parameter int TOKEN_WIDTH  = ptbl_pkg::TOKEN_WIDTH_DEFAULT,
   parameter int PERIOD_WIDTH = ptbl_pkg::PERIOD_WIDTH_DEFAULT
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    fire,
   input  wire logic                    func,
   input  wire logic [TOKEN_WIDTH-1:0]  amount,
   input  wire logic [TOKEN_WIDTH-1:0]  capacity,
   input  wire logic [PERIOD_WIDTH-1:0] period,
   output ptbl_pkg::status_type         status_o,
   output logic      [TOKEN_WIDTH-1:0]  level_o,
   output logic      [TOKEN_WIDTH-1:0]  owed_o
);
   import ptbl_pkg::*;

   logic [TOKEN_WIDTH-1:0]  level_ff, level_in;
   logic [TOKEN_WIDTH-1:0]  owed_ff, owed_in;
   logic [PERIOD_WIDTH-1:0] counter_ff, counter_in;
   logic                    pend_ff, pend_in;

   logic [PERIOD_WIDTH-1:0] cnt_inc;
   logic [TOKEN_WIDTH-1:0]  level_a, owed_a, chunk;
   logic                    pend_a, try_serve;
   status_type              status;

   always_comb begin
      cnt_inc    = counter_ff + PERIOD_WIDTH'(1);
      level_a    = level_ff;
      owed_a     = owed_ff;
      pend_a     = pend_ff;
      counter_in = counter_ff;
      status     = ST_IDLE;
      try_serve  = 1'b0;

      // Stage one: tick / request decode.
      if (func == FUNC_TICK) begin
         if (cnt_inc >= period) begin
            level_a    = capacity;   // refill sets, never adds
            counter_in = '0;
         end else begin
            counter_in = cnt_inc;
         end
         status    = pend_ff ? ST_WAITING : ST_IDLE;
         try_serve = pend_ff;
      end else if (pend_ff) begin
         status = ST_BUSY;
      end else if (amount == '0) begin
         status = ST_DONE;
      end else if (capacity == '0) begin
         status = ST_ZEROCAP;
      end else begin
         pend_a    = 1'b1;
         owed_a    = amount;
         status    = ST_WAITING;
         try_serve = 1'b1;
      end

      // Stage two: at most one chunk of min(owed, capacity).
      chunk    = (owed_a < capacity) ? owed_a : capacity;
      level_in = level_a;
      owed_in  = owed_a;
      pend_in  = pend_a;
      if (try_serve) begin
         if (level_a >= chunk) begin
            level_in = level_a - chunk;
            owed_in  = owed_a - chunk;
         end
         if (owed_in == '0) begin
            pend_in = 1'b0;
            status  = ST_DONE;
         end
      end
      if (!pend_in) begin
         owed_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff   <= '0;
         owed_ff    <= '0;
         counter_ff <= '0;
         pend_ff    <= 1'b0;
      end else if (fire) begin
         level_ff   <= level_in;
         owed_ff    <= owed_in;
         counter_ff <= counter_in;
         pend_ff    <= pend_in;
      end
   end

   assign status_o = status;
   assign level_o  = level_in;
   assign owed_o   = owed_in;

   `PTBL_ASSERT_NOW(a_owed_needs_pending, clock, reset, owed_ff != '0, pend_ff, "owed without pending request")
   `PTBL_ASSERT_NEXT(a_level_grows_on_tick_only, clock, reset, !(fire && func == FUNC_TICK), level_ff <= $past(level_ff), "bucket grew without a tick")
   `PTBL_ASSERT_NEXT(a_owed_never_grows, clock, reset, pend_ff, owed_ff <= $past(owed_ff), "owed grew while pending")

endmodule

`default_nettype wire

>>> rtl/periodic_token_bucket_limiter.sv
// Top level of the periodic token bucket rate limiter.
//
//   channel | direction | handshake            | payload
//   req_    | in        | req_valid/req_stall  | func, request_amount
//   rsp_    | out       | rsp_valid/rsp_stall  | status, tokens_held, tokens_owed
//   csr_    | in        | csr_valid/csr_ready  | csr_index, csr_data
//
// One word in, one word out, one word per cycle sustained while rsp_stall is low.
// Each word passes the input register, then the bucket update into the result register.
// The throughput limit is the single compare/subtract pass on bucket state per word.
// A word moves out of the input register only when the result register is free or drains.
// Synchronous active-high reset empties the bucket and clears the pending request.
// csr_ready is always high; registers take effect for the next word processed.
`default_nettype none

`include "periodic_token_bucket_limiter_defines.svh"

module periodic_token_bucket_limiter #(
   parameter int TOKEN_WIDTH  = ptbl_pkg::TOKEN_WIDTH_DEFAULT,
   parameter int PERIOD_WIDTH = ptbl_pkg::PERIOD_WIDTH_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // request channel
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic                                  req_func,
   input  wire logic [TOKEN_WIDTH-1:0]                req_request_amount,
   // result channel
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic [2:0]                                 rsp_status,
   output logic [TOKEN_WIDTH-1:0]                     rsp_tokens_held,
   output logic [TOKEN_WIDTH-1:0]                     rsp_tokens_owed,
   // register write channel
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [ptbl_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [(TOKEN_WIDTH > PERIOD_WIDTH ? TOKEN_WIDTH : PERIOD_WIDTH)-1:0] csr_data
);
   import ptbl_pkg::*;

   // Configuration registers
   logic [TOKEN_WIDTH-1:0]  capacity_ff;
   logic [PERIOD_WIDTH-1:0] period_ff;

   // Input register
   logic                    s1_valid_ff, s1_valid_in;
   logic                    s1_func_ff;
   logic [TOKEN_WIDTH-1:0]  s1_amount_ff;

   // Result register
   logic                    rsp_valid_ff, rsp_valid_in;
   status_type              rsp_status_ff;
   logic [TOKEN_WIDTH-1:0]  rsp_held_ff, rsp_owed_ff;

   // Engine outputs
   status_type              eng_status;
   logic [TOKEN_WIDTH-1:0]  eng_level, eng_owed;

   logic                    advance, req_take;

   // A buffered word proceeds when the result slot is empty or being taken.
   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         capacity_ff  <= '0;
         period_ff    <= PERIOD_WIDTH'(REFILL_PERIOD_RESET);
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_BUCKET_CAPACITY: capacity_ff <= csr_data[TOKEN_WIDTH-1:0];
               CSR_REFILL_PERIOD:   period_ff   <= csr_data[PERIOD_WIDTH-1:0];
               default: ;   // unmapped index, dropped
            endcase
         end
      end
   end

   // Payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_func_ff   <= req_func;
         s1_amount_ff <= req_request_amount;
      end
      if (advance) begin
         rsp_status_ff <= eng_status;
         rsp_held_ff   <= eng_level;
         rsp_owed_ff   <= eng_owed;
      end
   end

   ptbl_engine #(
      .TOKEN_WIDTH  (TOKEN_WIDTH),
      .PERIOD_WIDTH (PERIOD_WIDTH)
   ) u_engine (
      .clock    (clock),
      .reset    (reset),
      .fire     (advance),
      .func     (s1_func_ff),
      .amount   (s1_amount_ff),
      .capacity (capacity_ff),
      .period   (period_ff),
      .status_o (eng_status),
      .level_o  (eng_level),
      .owed_o   (eng_owed)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_tokens_held = rsp_held_ff;
   assign rsp_tokens_owed = rsp_owed_ff;

   `PTBL_ASSERT_NOW(a_done_owes_nothing, clock, reset, rsp_valid_ff && rsp_status_ff == ST_DONE, rsp_owed_ff == '0, "completed word still owes tokens")
   `PTBL_ASSERT_NOW(a_waiting_owes, clock, reset, rsp_valid_ff && rsp_status_ff == ST_WAITING, rsp_owed_ff != '0, "waiting word owes nothing")
   `PTBL_ASSERT_NOW(a_idle_owes_nothing, clock, reset, rsp_valid_ff && rsp_status_ff == ST_IDLE, rsp_owed_ff == '0, "idle word owes tokens")

endmodule

`default_nettype wire
